// ===== rtl/crc8_frame_sync_receiver_assert.svh =====
// Assertion macros for the CRC-8 frame receiver.
// Both sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef CRC8_FRAME_SYNC_RECEIVER_ASSERT_SVH
`define CRC8_FRAME_SYNC_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define CRC8FSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRC8FSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crc8fsr_pkg.sv =====
`timescale 1ns / 1ps
package crc8fsr_pkg;

  // CRC-8, polynomial 0x07, MSB first
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] CrcTop  = 8'h80;
  localparam logic [7:0] CrcInit = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Folds one byte into the running CRC: eight bit steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CrcTop) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/crc8_frame_sync_receiver.sv =====
`timescale 1ns / 1ps
`include "crc8_frame_sync_receiver_assert.svh"
// Byte-stream frame receiver. Bytes are taken one per beat while the input is
// not stalled; while no frame is open, every byte but start_byte is dropped.
// FRAME_BYTES bytes make a frame, whose last byte must equal CRC-8 (poly 0x07,
// init 0, MSB first) over the others. The completing byte stalls the input
// while one read port of the frame store is walked by a small sequencer: a CRC
// pass over all bytes but the last (one byte per cycle), a check state, then
// either FRAME_BYTES output beats (plus any output stall) or a resync search
// of the later stored bytes for the next start byte. The store is a ring with
// a base pointer, so realigning after a failed check moves no data.
// start_byte may only be written while the block is idle.
module crc8_frame_sync_receiver #(
  parameter int FRAME_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);
  import crc8fsr_pkg::*;

  localparam int IdxW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CntW = $clog2(FRAME_BYTES + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FRAME_BYTES - 1);
  localparam logic [IdxW-1:0] CrcLast  = IdxW'(FRAME_BYTES - 2);
  localparam logic [CntW-1:0] FullCnt  = CntW'(FRAME_BYTES);
  localparam logic [IdxW:0]   DepthExt = (IdxW + 1)'(FRAME_BYTES);

  // ring index: base plus offset, folded once
  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] base,
                                           input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthExt) begin
      sum = sum - DepthExt;
    end
    return sum[IdxW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] base_q, base_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      start_q;
  logic [7:0]      store_q [FRAME_BYTES];

  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_end_q, out_end_d;
  logic            out_valid_q, out_valid_d;

  logic            in_acc;
  logic            keep_byte;
  logic            frame_full;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]      rd_byte;
  logic            out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign keep_byte  = (fill_q != '0) || (rx_byte_i == start_q);
  assign frame_full = in_acc && keep_byte && (fill_q == FullCnt - CntW'(1));
  assign wr_idx     = wrap(base_q, fill_q[IdxW-1:0]);
  assign rd_idx     = wrap(base_q, k_q);
  assign rd_byte    = store_q[rd_idx];
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'h00;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  // frame store, no reset: only entries below the fill count are read
  always_ff @(posedge clk_i) begin
    if (in_acc && keep_byte) begin
      store_q[wr_idx] <= rx_byte_i;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    base_d      = base_q;
    k_d         = k_q;
    crc_d       = crc_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && keep_byte) begin
          fill_d = fill_q + CntW'(1);
        end
        if (frame_full) begin
          // frame complete: walk the CRC from the oldest byte
          state_d = ST_CRC;
          k_d     = '0;
          crc_d   = CrcInit;
        end
      end
      ST_CRC: begin
        crc_d = crc8_byte(crc_q, rd_byte);
        k_d   = k_q + IdxW'(1);
        if (k_q == CrcLast) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (crc_q == rd_byte) begin
          state_d = ST_EMIT;
          k_d     = '0;
        end else begin
          state_d = ST_SCAN;
          k_d     = IdxW'(1);
        end
      end
      ST_SCAN: begin
        if (rd_byte == start_q) begin
          base_d  = rd_idx;
          fill_d  = FullCnt - CntW'(k_q);
          state_d = ST_IDLE;
        end else if (k_q == LastIdx) begin
          fill_d  = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_byte_d  = rd_byte;
          out_end_d   = (k_q == LastIdx);
          out_valid_d = 1'b1;
          if (k_q == LastIdx) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      base_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      base_q      <= base_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;

  // checks
  `CRC8FSR_ASSERT_NOW(a_fill_below_full, state_q == ST_IDLE, fill_q < FullCnt, "full while idle")
  `CRC8FSR_ASSERT_NEXT(a_full_crc, frame_full, state_q == ST_CRC && k_q == '0, "no CRC walk")
  `CRC8FSR_ASSERT_NEXT(a_chk, state_q == ST_CHECK, state_q==ST_EMIT || state_q==ST_SCAN, "stuck")

endmodule
